### src/lprs_pkg.sv
`default_nettype none
package lprs_pkg;

  localparam int unsigned PAGE_SHIFT_DEF  = 12;
  localparam int unsigned LARGE_SHIFT_DEF = 21;
  localparam int unsigned HUGE_SHIFT_DEF  = 30;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned ADDR_W   = 4;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned NUM_SEGS = 5;

  localparam logic [1:0] REG_ENABLE_ALIGN = 2'd0;
  localparam logic [1:0] REG_NORMAL_CODE  = 2'd1;
  localparam logic [1:0] REG_CODE_2M      = 2'd2;
  localparam logic [1:0] REG_CODE_1G      = 2'd3;

  localparam logic       RST_ENABLE_ALIGN = 1'b1;
  localparam logic [7:0] RST_NORMAL_CODE  = 8'd1;
  localparam logic [7:0] RST_CODE_2M      = 8'd8;
  localparam logic [7:0] RST_CODE_1G      = 8'd9;

  typedef enum logic [1:0] {
    KIND_PASS,
    KIND_DROP,
    KIND_ONE,
    KIND_SPLIT
  } kind_e;

  typedef struct packed {
    logic       align_en;
    logic [7:0] normal_code;
    logic [7:0] code_2m;
    logic [7:0] code_1g;
  } cfg_t;

  typedef struct packed {
    kind_e       kind;
    logic [63:0] obase;
    logic [63:0] osize;
    logic [7:0]  otype;
    logic        last;
    logic [63:0] a;
    logic [63:0] f;
    logic [63:0] b;
    logic [63:0] e;
    logic [63:0] c;
    logic [63:0] d;
    logic [63:0] one_size;
  } stage_t;

  typedef struct packed {
    logic [NUM_SEGS-1:0][63:0] seg_base;
    logic [NUM_SEGS-1:0][63:0] seg_size;
    logic [NUM_SEGS-1:0][7:0]  seg_type;
    logic [NUM_SEGS-1:0]       mask;
    logic                      seg_valid;
    logic                      last;
  } entry_t;

  function automatic logic [63:0] ceil_align(input logic [63:0] x, input int unsigned sh);
    logic [63:0] m;
    m = (64'd1 << sh) - 64'd1;
    return (x + m) & ~m;
  endfunction

  function automatic logic [63:0] round_down(input logic [63:0] x, input int unsigned sh);
    logic [63:0] m;
    m = (64'd1 << sh) - 64'd1;
    return x & ~m;
  endfunction

  function automatic logic [63:0] gap(input logic [63:0] lo, input logic [63:0] hi);
    return (hi > lo) ? (hi - lo) : 64'd0;
  endfunction

endpackage
`default_nettype wire

### src/lprs_front.sv
`default_nettype none
module lprs_front #(
  parameter int unsigned PAGE_SHIFT  = lprs_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned LARGE_SHIFT = lprs_pkg::LARGE_SHIFT_DEF,
  parameter int unsigned HUGE_SHIFT  = lprs_pkg::HUGE_SHIFT_DEF
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire lprs_pkg::cfg_t  cfg_i,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic [63:0]     in_base_i,
  input  wire logic [63:0]     in_size_i,
  input  wire logic [7:0]      in_type_i,
  input  wire logic            in_last_i,
  output logic                 push_valid_o,
  input  wire logic            push_ready_i,
  output lprs_pkg::entry_t     push_entry_o
);

  logic            advance;
  logic            p1_valid_q, p2_valid_q, p3_valid_q;
  lprs_pkg::stage_t p1_d, p1_q, p2_d, p2_q, p3_d, p3_q;

  logic [63:0] end1, st, en;
  logic        changed, use_aligned;

  assign advance      = !p3_valid_q || push_ready_i;
  assign in_ready_o   = advance;
  assign push_valid_o = p3_valid_q;

  // align
  always_comb begin
    end1        = in_base_i + in_size_i;
    st          = lprs_pkg::ceil_align(in_base_i, PAGE_SHIFT);
    en          = lprs_pkg::round_down(end1, PAGE_SHIFT);
    changed     = (st != in_base_i) || (en != end1);
    use_aligned = cfg_i.align_en && changed;
    p1_d          = '0;
    p1_d.obase    = in_base_i;
    p1_d.osize    = in_size_i;
    p1_d.otype    = in_type_i;
    p1_d.last     = in_last_i;
    p1_d.a        = use_aligned ? st : in_base_i;
    p1_d.f        = use_aligned ? en : end1;
    if (in_type_i != cfg_i.normal_code) begin
      p1_d.kind = lprs_pkg::KIND_PASS;
    end else if (use_aligned && !(st < en)) begin
      p1_d.kind = lprs_pkg::KIND_DROP;
    end else begin
      p1_d.kind = lprs_pkg::KIND_SPLIT;
    end
  end

  // 2 MB bounds
  always_comb begin
    p2_d          = p1_q;
    p2_d.b        = lprs_pkg::ceil_align(p1_q.a, LARGE_SHIFT);
    p2_d.e        = lprs_pkg::round_down(p1_q.f, LARGE_SHIFT);
    p2_d.one_size = p1_q.f - p1_q.a;
    if (p1_q.kind == lprs_pkg::KIND_SPLIT && p2_d.e <= p2_d.b) begin
      p2_d.kind = lprs_pkg::KIND_ONE;
    end
  end

  // 1 GB bounds
  always_comb begin
    p3_d   = p2_q;
    p3_d.c = lprs_pkg::ceil_align(p2_q.b, HUGE_SHIFT);
    p3_d.d = lprs_pkg::round_down(p2_q.e, HUGE_SHIFT);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
    end else if (advance) begin
      p1_valid_q <= in_valid_i;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_q <= p1_d;
      p2_q <= p2_d;
      p3_q <= p3_d;
    end
  end

  // build segment list
  logic                              huge;
  logic [lprs_pkg::NUM_SEGS-1:0][63:0] sz;
  logic [lprs_pkg::NUM_SEGS-1:0]     piece_mask;

  always_comb begin
    huge  = p3_q.c < p3_q.d;
    sz[0] = lprs_pkg::gap(p3_q.a, p3_q.b);
    sz[4] = lprs_pkg::gap(p3_q.e, p3_q.f);
    sz[1] = huge ? lprs_pkg::gap(p3_q.b, p3_q.c) : lprs_pkg::gap(p3_q.b, p3_q.e);
    sz[2] = huge ? lprs_pkg::gap(p3_q.c, p3_q.d) : 64'd0;
    sz[3] = huge ? lprs_pkg::gap(p3_q.d, p3_q.e) : 64'd0;
    for (int i = 0; i < lprs_pkg::NUM_SEGS; i++) begin
      piece_mask[i] = (sz[i] >> PAGE_SHIFT) != 64'd0;
    end

    push_entry_o              = '0;
    push_entry_o.last         = p3_q.last;
    push_entry_o.seg_valid    = 1'b1;
    push_entry_o.mask         = 5'b00001;
    push_entry_o.seg_base[0]  = p3_q.a;
    push_entry_o.seg_size[0]  = p3_q.one_size;
    push_entry_o.seg_type[0]  = cfg_i.normal_code;
    unique case (p3_q.kind)
      lprs_pkg::KIND_PASS: begin
        push_entry_o.seg_base[0] = p3_q.obase;
        push_entry_o.seg_size[0] = p3_q.osize;
        push_entry_o.seg_type[0] = p3_q.otype;
      end
      lprs_pkg::KIND_DROP: begin
        push_entry_o.seg_base[0] = p3_q.obase;
        push_entry_o.seg_size[0] = 64'd0;
        push_entry_o.seg_type[0] = p3_q.otype;
        push_entry_o.seg_valid   = 1'b0;
      end
      lprs_pkg::KIND_ONE: begin
      end
      lprs_pkg::KIND_SPLIT: begin
        if (piece_mask != '0) begin
          push_entry_o.mask     = piece_mask;
          push_entry_o.seg_base = {p3_q.e, p3_q.d, p3_q.c, p3_q.b, p3_q.a};
          push_entry_o.seg_size = sz;
          push_entry_o.seg_type = {cfg_i.normal_code, cfg_i.code_2m, cfg_i.code_1g,
                                   cfg_i.code_2m, cfg_i.normal_code};
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

### src/lprs_queue.sv
`default_nettype none
module lprs_queue #(
  parameter int unsigned DEPTH = lprs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_valid_i,
  output logic                  push_ready_o,
  input  wire lprs_pkg::entry_t push_entry_i,
  output logic                  head_valid_o,
  input  wire logic             pop_i,
  output lprs_pkg::entry_t      head_entry_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

  lprs_pkg::entry_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign head_valid_o = count_q != '0;
  assign head_entry_o = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PTR_ONE;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PTR_ONE;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_ONE;
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

### src/lprs_back.sv
`default_nettype none
module lprs_back (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             head_valid_i,
  input  wire lprs_pkg::entry_t head_entry_i,
  output logic                  pop_o,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [63:0]           out_base_o,
  output logic [63:0]           out_size_o,
  output logic [7:0]            out_type_o,
  output logic                  out_seg_valid_o,
  output logic                  out_last_o,
  output logic                  out_done_o
);

  logic [lprs_pkg::NUM_SEGS-1:0] sent_q, sent_d, rem, pick;
  logic        load, is_last;
  logic [63:0] sel_base, sel_size;
  logic [7:0]  sel_type;
  logic        valid_q, valid_d;
  logic [63:0] base_q, size_q;
  logic [7:0]  type_q;
  logic        segv_q, last_q, done_q;

  always_comb begin
    rem      = head_entry_i.mask & ~sent_q;
    pick     = rem & (~rem + {{(lprs_pkg::NUM_SEGS-1){1'b0}}, 1'b1});
    is_last  = (rem & ~pick) == '0;
    sel_base = '0;
    sel_size = '0;
    sel_type = '0;
    for (int i = 0; i < lprs_pkg::NUM_SEGS; i++) begin
      if (pick[i]) begin
        sel_base = head_entry_i.seg_base[i];
        sel_size = head_entry_i.seg_size[i];
        sel_type = head_entry_i.seg_type[i];
      end
    end
    load    = head_valid_i && (!valid_q || out_ready_i);
    pop_o   = load && is_last;
    sent_d  = sent_q;
    valid_d = valid_q;
    if (load) begin
      sent_d  = is_last ? '0 : (sent_q | pick);
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sent_q  <= '0;
      valid_q <= 1'b0;
    end else begin
      sent_q  <= sent_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      base_q <= sel_base;
      size_q <= sel_size;
      type_q <= sel_type;
      segv_q <= head_entry_i.seg_valid;
      last_q <= is_last;
      done_q <= is_last && head_entry_i.last;
    end
  end

  assign out_valid_o     = valid_q;
  assign out_base_o      = base_q;
  assign out_size_o      = size_q;
  assign out_type_o      = type_q;
  assign out_seg_valid_o = segv_q;
  assign out_last_o      = last_q;
  assign out_done_o      = done_q;

endmodule
`default_nettype wire

### src/large_page_range_splitter_top.sv
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid / s_axis_tready  tdata {type,size,base}, tlast last_range
// m_axis   out  m_axis_tvalid / m_axis_tready  tdata {type,size,base}, tlast last_segment,
//                                              tuser {map_done,seg_valid}
// apb      in   psel / penable / pready        4 registers at byte address 4*i
//
// An entry yields one to five segments; the result side sends one segment per cycle
// while m_axis_tready is high, so an entry holds the back end until all its segments are sent.
// The front end takes one entry per cycle through three stages into the entry queue
// and stalls only when that queue is full; the back end takes entries from the queue head.
// Reset clears pipeline valids, queue pointers and segment cursor and loads register defaults; no clearing pass.
// A stalled result holds in the output register while the back end waits.
`default_nettype none
module large_page_range_splitter_top #(
  parameter int unsigned PAGE_SHIFT  = lprs_pkg::PAGE_SHIFT_DEF,
  parameter int unsigned LARGE_SHIFT = lprs_pkg::LARGE_SHIFT_DEF,
  parameter int unsigned HUGE_SHIFT  = lprs_pkg::HUGE_SHIFT_DEF,
  parameter int unsigned QUEUE_DEPTH = lprs_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  input  wire logic [135:0]                s_axis_tdata,  // range_base, range_size, range_type
  input  wire logic                        s_axis_tlast,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  output logic [135:0]                     m_axis_tdata,  // seg_base, seg_size, seg_type
  output logic [1:0]                       m_axis_tuser,  // seg_valid, map_done
  output logic                             m_axis_tlast,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [lprs_pkg::ADDR_W-1:0] paddr,
  input  wire logic [lprs_pkg::DATA_W-1:0] pwdata,
  output logic [lprs_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  lprs_pkg::cfg_t   cfg_q;
  logic             cfg_wr;
  logic             push_valid, push_ready, head_valid, pop;
  lprs_pkg::entry_t push_entry, head_entry;
  logic [63:0]      out_base, out_size;
  logic [7:0]       out_type;
  logic             out_segv, out_done;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.align_en    <= lprs_pkg::RST_ENABLE_ALIGN;
      cfg_q.normal_code <= lprs_pkg::RST_NORMAL_CODE;
      cfg_q.code_2m     <= lprs_pkg::RST_CODE_2M;
      cfg_q.code_1g     <= lprs_pkg::RST_CODE_1G;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lprs_pkg::REG_ENABLE_ALIGN: cfg_q.align_en    <= pwdata[0];
        lprs_pkg::REG_NORMAL_CODE:  cfg_q.normal_code <= pwdata[7:0];
        lprs_pkg::REG_CODE_2M:      cfg_q.code_2m     <= pwdata[7:0];
        lprs_pkg::REG_CODE_1G:      cfg_q.code_1g     <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      lprs_pkg::REG_ENABLE_ALIGN: prdata[0]   = cfg_q.align_en;
      lprs_pkg::REG_NORMAL_CODE:  prdata[7:0] = cfg_q.normal_code;
      lprs_pkg::REG_CODE_2M:      prdata[7:0] = cfg_q.code_2m;
      lprs_pkg::REG_CODE_1G:      prdata[7:0] = cfg_q.code_1g;
      default: begin
      end
    endcase
  end

  lprs_front #(
    .PAGE_SHIFT (PAGE_SHIFT),
    .LARGE_SHIFT(LARGE_SHIFT),
    .HUGE_SHIFT (HUGE_SHIFT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_base_i   (s_axis_tdata[63:0]),
    .in_size_i   (s_axis_tdata[127:64]),
    .in_type_i   (s_axis_tdata[135:128]),
    .in_last_i   (s_axis_tlast),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_entry_o(push_entry)
  );

  lprs_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .head_valid_o(head_valid),
    .pop_i       (pop),
    .head_entry_o(head_entry)
  );

  lprs_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .head_valid_i   (head_valid),
    .head_entry_i   (head_entry),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_base_o     (out_base),
    .out_size_o     (out_size),
    .out_type_o     (out_type),
    .out_seg_valid_o(out_segv),
    .out_last_o     (m_axis_tlast),
    .out_done_o     (out_done)
  );

  assign m_axis_tdata = {out_type, out_size, out_base};
  assign m_axis_tuser = {out_done, out_segv};

endmodule
`default_nettype wire

### tb/sv/large_page_range_splitter_top_test.sv
`timescale 1ns / 100ps
module large_page_range_splitter_top_test;

  localparam int unsigned PG = lprs_pkg::PAGE_SHIFT_DEF;
  localparam int unsigned LG = lprs_pkg::LARGE_SHIFT_DEF;
  localparam int unsigned HG = lprs_pkg::HUGE_SHIFT_DEF;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned RANGES_PER_PHASE = 37;
  localparam int unsigned NUM_PHASES = 4;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [7:0]  kind;
    logic        valid;
    logic        tail;
    logic        done;
  } seg_rec_t;

  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [7:0]  rtype;
    logic        last;
    logic        fixed;
    logic        want_valid;
  } dir_row_t;

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        s_axis_tvalid = 1'b0;
  logic                        s_axis_tready;
  logic [135:0]                s_axis_tdata = '0;  // range_base, range_size, range_type
  logic                        s_axis_tlast = 1'b0;
  logic                        m_axis_tvalid;
  logic                        m_axis_tready = 1'b0;
  logic [135:0]                m_axis_tdata;       // seg_base, seg_size, seg_type
  logic [1:0]                  m_axis_tuser;       // seg_valid, map_done
  logic                        m_axis_tlast;
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [lprs_pkg::ADDR_W-1:0] paddr = '0;
  logic [lprs_pkg::DATA_W-1:0] pwdata = '0;
  logic [lprs_pkg::DATA_W-1:0] prdata;
  logic                        pready;

  seg_rec_t       owed_segs[$];
  lprs_pkg::cfg_t shadow_cfg = '{lprs_pkg::RST_ENABLE_ALIGN, lprs_pkg::RST_NORMAL_CODE,
                                 lprs_pkg::RST_CODE_2M, lprs_pkg::RST_CODE_1G};
  int unsigned    mismatches = 0;
  int unsigned    cycles = 0;
  logic           calm = 1'b0;

  dir_row_t dir_rows [22] = '{
    '{64'h0, 64'h0, 8'h00, 1'b0, 1'b1, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 1'b1, 1'b1, 1'b1},
    '{64'h123, 64'h10, 8'h02, 1'b0, 1'b1, 1'b1},
    '{64'h1001, 64'h100, 8'h01, 1'b0, 1'b1, 1'b0},
    '{64'hFFF, 64'h1, 8'h01, 1'b1, 1'b1, 1'b0},
    '{64'h800, 64'h1000, 8'h01, 1'b0, 1'b1, 1'b0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555, 8'h80, 1'b1, 1'b1, 1'b1},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_F001, 64'h2000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h2000, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h0, 64'h0, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h1000, 64'h1000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h20_0000, 64'h20_0000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h1F_F000, 64'h40_2000, 8'h01, 1'b1, 1'b0, 1'b0},
    '{64'h3FE0_0000, 64'h8040_0000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h3FDF_F800, 64'h1_0040_1000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h1F_FF00, 64'h20_0200, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 8'h01, 1'b1, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_C000_0000, 64'h8000_0000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'hFFFF_FFFF_FFE0_0000, 64'h40_0000, 8'h01, 1'b0, 1'b0, 1'b0},
    '{64'h4000_0000, 64'h4000_0000, 8'h01, 1'b1, 1'b0, 1'b0},
    '{64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, 8'h01, 1'b0, 1'b0, 1'b0}
  };

  lprs_pkg::cfg_t phase_cfgs [NUM_PHASES] = '{
    '{1'b0, 8'h00, 8'hFF, 8'h00},
    '{1'b1, 8'hFF, 8'h00, 8'hFF},
    '{1'b1, 8'h3C, 8'hC3, 8'h5A},
    '{1'b0, 8'h7F, 8'h80, 8'h01}
  };

  large_page_range_splitter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [63:0] ceil_to(input logic [63:0] x, input int unsigned sh);
    logic [63:0] m;
    m = (64'd1 << sh) - 64'd1;
    return (x + m) & ~m;
  endfunction

  function automatic logic [63:0] floor_to(input logic [63:0] x, input int unsigned sh);
    return x & ~((64'd1 << sh) - 64'd1);
  endfunction

  function automatic logic [63:0] span(input logic [63:0] lo, input logic [63:0] hi);
    return (hi > lo) ? hi - lo : 64'd0;
  endfunction

  function automatic seg_rec_t seg_of(input logic [63:0] b, input logic [63:0] s,
                                      input logic [7:0] t, input logic v);
    return '{b, s, t, v, 1'b0, 1'b0};
  endfunction

  function automatic logic [63:0] wide();
    return {$urandom, $urandom};
  endfunction

  function automatic void split_range(input logic [63:0] rbase, input logic [63:0] rsize,
                                      input logic [7:0] rtype, input logic rlast);
    seg_rec_t    made[$];
    seg_rec_t    closing;
    logic [63:0] base, size, fin, st, en, a, b, c, d, e, f;
    logic [63:0] pb [5];
    logic [63:0] ps [5];
    logic [7:0]  pt [5];
    logic        dropped;
    base = rbase;
    size = rsize;
    dropped = 1'b0;
    if (rtype != shadow_cfg.normal_code) begin
      made.push_back(seg_of(rbase, rsize, rtype, 1'b1));
    end else begin
      if (shadow_cfg.align_en) begin
        fin = rbase + rsize;
        st = ceil_to(rbase, PG);
        en = floor_to(fin, PG);
        if (st != rbase || en != fin) begin
          if (st < en) begin
            base = st;
            size = en - st;
          end else begin
            dropped = 1'b1;
          end
        end
      end
      if (dropped) begin
        made.push_back(seg_of(rbase, 64'd0, rtype, 1'b0));
      end else begin
        a = base;
        f = base + size;
        b = ceil_to(a, LG);
        e = floor_to(f, LG);
        if (e <= b) begin
          made.push_back(seg_of(base, size, shadow_cfg.normal_code, 1'b1));
        end else begin
          c = ceil_to(b, HG);
          d = floor_to(e, HG);
          pb = '{a, b, c, d, e};
          pt = '{shadow_cfg.normal_code, shadow_cfg.code_2m, shadow_cfg.code_1g,
                 shadow_cfg.code_2m, shadow_cfg.normal_code};
          if (c < d) begin
            ps = '{span(a, b), span(b, c), span(c, d), span(d, e), span(e, f)};
          end else begin
            ps = '{span(a, b), span(b, e), 64'd0, 64'd0, span(e, f)};
          end
          for (int i = 0; i < 5; i++) begin
            if ((ps[i] >> PG) != 64'd0) begin
              made.push_back(seg_of(pb[i], ps[i], pt[i], 1'b1));
            end
          end
          if (made.size() == 0) begin
            made.push_back(seg_of(base, size, shadow_cfg.normal_code, 1'b1));
          end
        end
      end
    end
    closing = made.pop_back();
    closing.tail = 1'b1;
    closing.done = rlast;
    made.push_back(closing);
    foreach (made[k]) owed_segs.push_back(made[k]);
  endfunction

  task automatic send_range(input logic [63:0] rbase, input logic [63:0] rsize,
                            input logic [7:0] rtype, input logic rlast);
    if (!calm && $urandom_range(0, 99) < 22) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < 22);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {rtype, rsize, rbase};
    s_axis_tlast <= rlast;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic drain_segs();
    s_axis_tvalid <= 1'b0;
    while (owed_segs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input lprs_pkg::cfg_t cfg);
    logic [1:0]                  idx;
    logic [lprs_pkg::DATA_W-1:0] val;
    for (int r = 0; r < 4; r++) begin
      idx = 2'(r);
      case (idx)
        lprs_pkg::REG_ENABLE_ALIGN: val = {31'($urandom), cfg.align_en};
        lprs_pkg::REG_NORMAL_CODE:  val = {24'($urandom), cfg.normal_code};
        lprs_pkg::REG_CODE_2M:      val = {24'($urandom), cfg.code_2m};
        default:                    val = {24'($urandom), cfg.code_1g};
      endcase
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= val;
      @(posedge clk_i);
      penable <= 1'b1;
      do @(posedge clk_i); while (!pready);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    shadow_cfg = cfg;
  endtask

  task automatic draw_range(output logic [63:0] rb, output logic [63:0] rs,
                            output logic [7:0] rt, output logic rl);
    int unsigned pick;
    int unsigned sh;
    pick = $urandom_range(0, 99);
    rt = shadow_cfg.normal_code;
    rl = ($urandom_range(0, 7) == 0);
    if (pick < 15) begin
      rb = wide();
      rs = wide();
      rt = 8'($urandom);
      if (rt == shadow_cfg.normal_code) rt = ~rt;
    end else if (pick < 27) begin
      rb = wide();
      rs = wide();
    end else if (pick < 40) begin
      rb = wide();
      rs = 64'($urandom_range(0, 12288));
    end else begin
      // page-structured range with random offsets, sometimes near the top of the space
      sh = $urandom_range(PG, 34);
      rb = wide() & ~((64'd1 << sh) - 64'd1);
      if ($urandom_range(0, 7) == 0) rb = rb | 64'hFFFF_FFF0_0000_0000;
      rb = rb + (64'($urandom_range(0, 3)) << $urandom_range(PG, HG));
      if ($urandom_range(0, 1) == 0) rb = rb + 64'($urandom_range(1, 4095));
      rs = 64'($urandom_range(1, 6)) << $urandom_range(PG, 32);
      if ($urandom_range(0, 1) == 0) begin
        rs = rs + (64'($urandom_range(0, 3)) << $urandom_range(PG, 29));
      end
      if ($urandom_range(0, 1) == 0) rs = rs + 64'($urandom_range(0, 4095));
    end
  endtask

  always @(posedge clk_i) begin
    seg_rec_t got;
    seg_rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{m_axis_tdata[63:0], m_axis_tdata[127:64], m_axis_tdata[135:128],
              m_axis_tuser[0], m_axis_tlast, m_axis_tuser[1]};
      if (owed_segs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("%0t unexpected segment base %h size %h type %h valid %b last %b done %b",
                   $realtime, got.base, got.size, got.kind, got.valid, got.tail, got.done);
        end
      end else begin
        want = owed_segs.pop_front();
        if (got.base !== want.base || got.size !== want.size || got.kind !== want.kind ||
            got.valid !== want.valid || got.tail !== want.tail || got.done !== want.done) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t segment mismatch: got base %h size %h type %h valid %b last %b done %b",
                     $realtime, got.base, got.size, got.kind, got.valid, got.tail, got.done);
            $display("%0t                  want base %h size %h type %h valid %b last %b done %b",
                     $realtime, want.base, want.size, want.kind, want.valid, want.tail,
                     want.done);
          end
        end
      end
    end
    m_axis_tready <= calm || ($urandom_range(0, 99) >= 22);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("large_page_range_splitter_top test failed");
      $finish;
    end
  end

  initial begin
    logic [63:0]    rb, rs;
    logic [7:0]     rt;
    logic           rl;
    lprs_pkg::cfg_t cfg;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_rows[k]) begin
      send_range(dir_rows[k].base, dir_rows[k].size, dir_rows[k].rtype, dir_rows[k].last);
      if (dir_rows[k].fixed) begin
        owed_segs.push_back('{dir_rows[k].base,
                              dir_rows[k].want_valid ? dir_rows[k].size : 64'd0,
                              dir_rows[k].rtype, dir_rows[k].want_valid, 1'b1,
                              dir_rows[k].last});
      end else begin
        split_range(dir_rows[k].base, dir_rows[k].size, dir_rows[k].rtype, dir_rows[k].last);
      end
    end
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // hold off until every segment is out before touching the registers
      drain_segs();
      cfg = phase_cfgs[ph];
      if (ph == 2) cfg = '{1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)};
      write_config(cfg);
      calm <= (ph == 2);
      repeat (RANGES_PER_PHASE) begin
        draw_range(rb, rs, rt, rl);
        send_range(rb, rs, rt, rl);
        split_range(rb, rs, rt, rl);
      end
    end
    s_axis_tvalid <= 1'b0;
    while (owed_segs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && owed_segs.size() == 0) begin
      $display("large_page_range_splitter_top test passed");
    end else begin
      $display("large_page_range_splitter_top test failed");
    end
    $finish;
  end

endmodule
